>>> hw/rtl/miller_rabin_primality_test_macros.svh
// assertion macros for the miller-rabin primality test block
// used by the top level only; no other dependencies
`ifndef MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH

// same-cycle implication, checked out of reset
`define MR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mr assertion failed");

// next-cycle implication, checked out of reset
`define MR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mr assertion failed");

`endif

>>> hw/rtl/mr_pkg.sv
// shared constants, witness table and status type for the primality tester
// no dependencies
package mr_pkg;

  localparam int MR_IN_WIDTH   = 32;  // width of the candidate port
  localparam int MR_NUM_WIDTH  = 32;  // default number of candidate bits used
  localparam int MR_NUM_BASES  = 12;  // default number of witness bases
  localparam int MR_BASE_WIDTH = 6;   // largest witness is 37
  localparam int MR_TBL_IDX_W  = 4;   // twelve table entries

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mr_mul_stat_t;

  // witness bases 2..37 in test order
  function automatic logic [MR_BASE_WIDTH-1:0] mr_base(input logic [MR_TBL_IDX_W-1:0] idx);
    logic [MR_BASE_WIDTH-1:0] w;
    case (idx)
      4'd0:    w = 6'd2;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd5;
      4'd3:    w = 6'd7;
      4'd4:    w = 6'd11;
      4'd5:    w = 6'd13;
      4'd6:    w = 6'd17;
      4'd7:    w = 6'd19;
      4'd8:    w = 6'd23;
      4'd9:    w = 6'd29;
      4'd10:   w = 6'd31;
      4'd11:   w = 6'd37;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/mr_modmul.sv
// bit-serial interleaved modular multiplier: a * b mod m, one bit of b per cycle
// depends on mr_pkg; operands must be below m
module mr_modmul #(
  parameter int NUM_WIDTH = mr_pkg::MR_NUM_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUM_WIDTH-1:0]   op_a,
  input  logic [NUM_WIDTH-1:0]   op_b,
  input  logic [NUM_WIDTH-1:0]   modulus,
  output logic [NUM_WIDTH-1:0]   result,
  output mr_pkg::mr_mul_stat_t   stat
);
  import mr_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH);
  localparam int TW = NUM_WIDTH + 2;

  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUM_WIDTH-1:0] a_r, a_nxt;
  logic [NUM_WIDTH-1:0] b_r, b_nxt;
  logic [NUM_WIDTH-1:0] m_r, m_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TW-1:0] sum;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  logic [TW-1:0] red;

  // one step: acc = (2*acc + bit*a) mod m, sum stays below 3m
  always_comb begin
    m1  = TW'(m_r);
    m2  = {1'b0, m_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (b_r[NUM_WIDTH-1] ? TW'(a_r) : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  // load on start, then walk b from its top bit
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      m_nxt    = modulus;
      cnt_nxt  = CW'(NUM_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = red[NUM_WIDTH-1:0];
      b_nxt   = {b_r[NUM_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/miller_rabin_primality_test.sv
// top level of the deterministic miller-rabin primality tester
// depends on mr_pkg, mr_modmul and miller_rabin_primality_test_macros.svh
//
//  channel | ports                      | direction
//  --------+----------------------------+----------
//  input   | in_valid in_stall in_candidate | in (stall out)
//  result  | out_valid out_stall out_is_prime | out (stall in)
//
// one candidate at a time; in_stall stays high from acceptance until the result is
// handed to the output register. every modular product runs on the single shared
// bit-serial multiplier, which sets the rate: a base costs up to about 2 * NUM_WIDTH
// products. values below 2 and the value 2 finish without a modular product; any
// other value equal to a base first runs the full test for every smaller base.
// synchronous active-low reset clears the sequencer and output valid; the output register
// holds its word under out_stall while the next candidate is already being tested.
module miller_rabin_primality_test #(
  parameter int NUM_WIDTH = mr_pkg::MR_NUM_WIDTH,
  parameter int NUM_BASES = mr_pkg::MR_NUM_BASES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mr_pkg::MR_IN_WIDTH-1:0]  in_candidate,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_prime
);
  import mr_pkg::*;

`include "miller_rabin_primality_test_macros.svh"

  localparam int W  = NUM_WIDTH;
  localparam int CW = $clog2(NUM_WIDTH);
  localparam int BW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECOMP,
    S_BASE,
    S_REDUCE,
    S_EXP,
    S_WAIT_ACC,
    S_WAIT_B,
    S_TEST,
    S_LOOP,
    S_WAIT_X,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  nm1_r, nm1_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  ex_r, ex_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_prime_r, out_prime_nxt;

  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  mul_res;
  mr_mul_stat_t  mul_stat;

  logic [W-1:0]  n_in;
  logic [W-1:0]  base_w;
  logic          last_base;

  assign n_in      = in_candidate[W-1:0];
  assign base_w    = W'(mr_base(MR_TBL_IDX_W'(idx_r)));
  assign last_base = (idx_r == BW'(NUM_BASES - 1));

  // shared modular multiplier
  mr_modmul #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (n_r),
    .result  (mul_res),
    .stat    (mul_stat)
  );

  // sequencer: decompose n-1, then per base a modular power and the squaring chain
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nm1_nxt       = nm1_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    ex_nxt        = ex_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_prime_nxt = out_prime_r;
    mul_start     = 1'b0;
    mul_a         = acc_r;
    mul_b         = b_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt   = n_in;
          nm1_nxt = n_in - 1'b1;
          d_nxt   = n_in - 1'b1;
          r_nxt   = '0;
          idx_nxt = '0;
          if (n_in < W'(2)) begin
            res_nxt   = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_DECOMP;
          end
        end
      end
      // strip factors of two, one per cycle
      S_DECOMP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          r_nxt = r_r + 1'b1;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        if (n_r == base_w) begin
          res_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          b_nxt     = base_w;
          acc_nxt   = W'(1);
          ex_nxt    = d_r;
          state_nxt = S_REDUCE;
        end
      end
      // base mod n by repeated subtraction, base is small
      S_REDUCE: begin
        if (b_r >= n_r) begin
          b_nxt = b_r - n_r;
        end else begin
          state_nxt = S_EXP;
        end
      end
      // right-to-left square and multiply
      S_EXP: begin
        if (ex_r[0]) begin
          mul_start = 1'b1;
          state_nxt = S_WAIT_ACC;
        end else if (ex_r[W-1:1] != '0) begin
          mul_a     = b_r;
          mul_start = 1'b1;
          state_nxt = S_WAIT_B;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_WAIT_ACC: begin
        if (mul_stat.done) begin
          acc_nxt   = mul_res;
          ex_nxt    = {ex_r[W-1:1], 1'b0};
          state_nxt = S_EXP;
        end
      end
      S_WAIT_B: begin
        if (mul_stat.done) begin
          b_nxt     = mul_res;
          ex_nxt    = ex_r >> 1;
          state_nxt = S_EXP;
        end
      end
      S_TEST: begin
        if (acc_r == W'(1) || acc_r == nm1_r) begin
          if (last_base) begin
            res_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_BASE;
          end
        end else begin
          k_nxt     = CW'(1);
          state_nxt = S_LOOP;
        end
      end
      // square up to r-1 times looking for n-1
      S_LOOP: begin
        if (k_r < r_r) begin
          mul_b     = acc_r;
          mul_start = 1'b1;
          state_nxt = S_WAIT_X;
        end else begin
          res_nxt   = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_WAIT_X: begin
        mul_b = acc_r;
        if (mul_stat.done) begin
          acc_nxt = mul_res;
          if (mul_res == nm1_r) begin
            if (last_base) begin
              res_nxt   = 1'b1;
              state_nxt = S_FINISH;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_BASE;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_LOOP;
          end
        end
      end
      // hand the word to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    nm1_r       <= nm1_nxt;
    d_r         <= d_nxt;
    r_r         <= r_nxt;
    k_r         <= k_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    b_r         <= b_nxt;
    ex_r        <= ex_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  // checks on sequencing
  `MR_ASSERT_NOW(a_mul_busy_stalls, clk, rst_n, mul_stat.busy, in_stall)
  `MR_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `MR_ASSERT_NOW(a_done_after_busy, clk, rst_n, mul_stat.done, $past(mul_stat.busy))
  `MR_ASSERT_NOW(a_start_when_idle_unit, clk, rst_n, mul_start, !mul_stat.busy)

endmodule
